FILE: rtl/heightfield_normal_stream_assert.svh
// Assertion macros used by the checker file of the height-field normal stream.
`ifndef HEIGHTFIELD_NORMAL_STREAM_ASSERT_SVH
`define HEIGHTFIELD_NORMAL_STREAM_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HNS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HNS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/hns_pkg.sv
// Shared types, constants and helper functions of the height-field normal stream.
package hns_pkg;

  localparam int unsigned MAX_WIDTH_DEF = 1024;

  localparam int unsigned SAMPLE_W = 17;
  localparam int unsigned STEPS_W  = 6;
  localparam int unsigned QUO_STEPS_GRAD = 32;
  localparam int unsigned QUO_STEPS_UNIT = 16;
  localparam int unsigned ROOT_STEPS     = 32;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_GRID_WIDTH  = 3'd0,
    CFG_GRID_HEIGHT = 3'd1,
    CFG_MAX_HEIGHT  = 3'd2,
    CFG_CELL_X      = 3'd3,
    CFG_CELL_Z      = 3'd4
  } cfg_idx_t;

  // Operations of the shared iterative unit.
  typedef enum logic {
    OP_DIV  = 1'b0,
    OP_SQRT = 1'b1
  } unit_op_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PICK,
    ST_READ,
    ST_MUL_WH,
    ST_MUL_AX,
    ST_DIV_X,
    ST_MUL_AZ,
    ST_DIV_Z,
    ST_SQ_X,
    ST_SQ_Z,
    ST_SUM,
    ST_SQRT,
    ST_DIV_NX,
    ST_DIV_NY,
    ST_DIV_NZ,
    ST_OUT
  } state_t;

  // Request to the iterative unit.
  typedef struct packed {
    logic                start;
    unit_op_t            op;
    logic [STEPS_W-1:0]  steps;
  } unit_req_t;

  // Status of the iterative unit.
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  // Clamp a raw Q1.16 sample to 0 .. 1.0.
  function automatic logic [SAMPLE_W-1:0] clamp_sample(input logic signed [17:0] raw);
    logic [SAMPLE_W-1:0] res;
    if (raw[17]) begin
      res = '0;
    end else if (raw[16:0] > 17'd65536) begin
      res = 17'd65536;
    end else begin
      res = raw[16:0];
    end
    return res;
  endfunction

  // Line slot that lies a given number of rows behind the newest one.
  function automatic logic [1:0] slot_back(input logic [1:0] newest, input logic [1:0] back);
    logic [1:0] res;
    case (back)
      2'd0:    res = newest;
      2'd1:    res = (newest == 2'd0) ? 2'd2 : newest - 2'd1;
      default: res = (newest == 2'd2) ? 2'd0 : ((newest == 2'd1) ? 2'd2 : 2'd1);
    endcase
    return res;
  endfunction

endpackage

FILE: rtl/hns_if.sv
// Valid/ready channel interfaces for samples in and results out.
interface hns_in_if;
  logic               valid;
  logic               ready;
  logic signed [17:0] height_sample;

  modport source (output valid, output height_sample, input ready);
  modport sink   (input valid, input height_sample, output ready);
endinterface

interface hns_out_if;
  logic               valid;
  logic               ready;
  logic        [9:0]  grid_col;
  logic        [15:0] grid_row;
  logic        [15:0] world_height;
  logic signed [15:0] normal_x;
  logic        [14:0] normal_y;
  logic signed [15:0] normal_z;
  logic               last_of_run;

  modport source (output valid, output grid_col, output grid_row, output world_height,
                  output normal_x, output normal_y, output normal_z, output last_of_run,
                  input ready);
  modport sink   (input valid, input grid_col, input grid_row, input world_height,
                  input normal_x, input normal_y, input normal_z, input last_of_run,
                  output ready);
endinterface

FILE: rtl/hns_store.sv
// Three-line sample store: one write port and one registered read port.
module hns_store #(
  parameter int unsigned DEPTH = 3 * hns_pkg::MAX_WIDTH_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [AW-1:0]                waddr,
  input  logic [hns_pkg::SAMPLE_W-1:0] wdata,
  input  logic [AW-1:0]                raddr,
  output logic [hns_pkg::SAMPLE_W-1:0] rdata_r
);

  logic [hns_pkg::SAMPLE_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

endmodule

FILE: rtl/hns_unit.sv
// Shared iterative unit: restoring division and integer square root, one bit per cycle.
module hns_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  hns_pkg::unit_req_t req,
  input  logic [63:0]        operand,
  input  logic [63:0]        divisor_aligned,
  output hns_pkg::unit_stat_t stat,
  output logic [31:0]        result
);

  localparam logic [63:0] ROOT_START = 64'h4000_0000_0000_0000;

  hns_pkg::unit_op_t            op_r;
  logic [63:0]                  rem_r, rem_nxt;
  logic [63:0]                  cmp_r, cmp_nxt;
  logic [63:0]                  root_r, root_nxt;
  logic [hns_pkg::STEPS_W-1:0]  cnt_r;
  logic                         busy_r, done_r;
  logic [63:0]                  sub;
  logic                         ge;

  // One compare and subtract step.
  always_comb begin
    sub = (op_r == hns_pkg::OP_SQRT) ? (root_r | cmp_r) : cmp_r;
    ge  = rem_r >= sub;
    rem_nxt = ge ? rem_r - sub : rem_r;
    if (op_r == hns_pkg::OP_SQRT) begin
      root_nxt = ge ? ((root_r >> 1) | cmp_r) : (root_r >> 1);
      cmp_nxt  = cmp_r >> 2;
    end else begin
      root_nxt = {root_r[62:0], ge};
      cmp_nxt  = cmp_r >> 1;
    end
  end

  // Control: step counter and completion pulse.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == hns_pkg::STEPS_W'(1));
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - hns_pkg::STEPS_W'(1);
        if (cnt_r == hns_pkg::STEPS_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (req.start) begin
      op_r   <= req.op;
      rem_r  <= operand;
      root_r <= '0;
      cmp_r  <= (req.op == hns_pkg::OP_SQRT) ? ROOT_START : divisor_aligned;
    end else if (busy_r) begin
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      cmp_r  <= cmp_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign result    = root_r[31:0];

endmodule

FILE: rtl/heightfield_normal_stream.sv
// Top level of the height-field normal stream: counters, sequencer, multiplier, output.
// A sample that causes results has them worked out one after another; each result takes the
// shared unit through two 32-step divisions, a 32-step root and three 16-step ones.
// The block takes no new sample until the sequencer is back in idle.
// Reset (synchronous, rst_n low) clears counters and sequencer and loads register defaults.
module heightfield_normal_stream #(
  parameter int unsigned MAX_WIDTH = hns_pkg::MAX_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  hns_in_if.sink      in_ch,
  hns_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam int unsigned DEPTH = 3 * MAX_WIDTH;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned WW    = (CW > 11) ? CW : 11;
  localparam int unsigned SW    = hns_pkg::SAMPLE_W;

  // Configuration registers.
  logic [10:0] grid_width_r;
  logic [15:0] grid_height_r, max_height_r, cell_x_r, cell_z_r;

  // Frame position.
  logic [WW-1:0] col_r;
  logic [15:0]   row_r;
  logic [1:0]    slot_r;

  // Per-sample and per-result registers.
  hns_pkg::state_t state_r, state_nxt;
  logic [WW-1:0] stc_r, sw_r, x_r;
  logic [15:0]   str_r, sh_r, y_r;
  logic [1:0]    sts_r;
  logic [2:0]    pend_r;
  logic          last_r;
  logic [2:0]    rd_cnt_r;
  logic [SW-1:0] hs_r, hl_r, hr_r, hd_r, hu_r;
  logic [63:0]   prod_r, acc_r;
  logic [15:0]   wh_r;
  logic [31:0]   gx_r, gz_r, s_r;
  logic [14:0]   nx_r, ny_r;
  logic          launched_r;

  // Output register.
  logic [9:0]  o_col_r;
  logic [15:0] o_row_r, o_wh_r;
  logic [15:0] o_nx_r, o_nz_r;
  logic [14:0] o_ny_r;
  logic        o_last_r;

  function automatic logic [AW-1:0] line_addr(input logic [1:0] s, input logic [WW-1:0] c);
    logic [AW-1:0] base;
    case (s)
      2'd0:    base = '0;
      2'd1:    base = AW'(MAX_WIDTH);
      default: base = AW'(2 * MAX_WIDTH);
    endcase
    return base + AW'(c);
  endfunction

  // Effective grid size and restart check.
  logic [WW-1:0] w_eff, c0;
  logic [15:0]   h_eff, r0;
  logic          restart, accept;
  always_comb begin
    if (WW'(grid_width_r) < WW'(2)) begin
      w_eff = WW'(2);
    end else if (WW'(grid_width_r) > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(grid_width_r);
    end
    h_eff   = (grid_height_r < 16'd2) ? 16'd2 : grid_height_r;
    restart = (col_r >= w_eff) || (row_r >= h_eff);
    c0      = restart ? '0 : col_r;
    r0      = restart ? '0 : row_r;
  end

  assign accept = in_ch.valid && in_ch.ready;

  // Neighbor coordinates of the point being worked on.
  logic [WW-1:0] lx, rx;
  logic [15:0]   dy, uy;
  logic [1:0]    slot_y, slot_dy, slot_uy;
  always_comb begin
    lx = (x_r == '0) ? '0 : x_r - WW'(1);
    rx = (x_r + WW'(1) >= sw_r) ? sw_r - WW'(1) : x_r + WW'(1);
    dy = (y_r == '0) ? '0 : y_r - 16'd1;
    uy = (y_r + 16'd1 >= sh_r) ? sh_r - 16'd1 : y_r + 16'd1;
    slot_y  = hns_pkg::slot_back(sts_r, 2'(str_r - y_r));
    slot_dy = hns_pkg::slot_back(sts_r, 2'(str_r - dy));
    slot_uy = hns_pkg::slot_back(sts_r, 2'(str_r - uy));
  end

  // Read address sequence: self, left, right, down, up.
  logic [AW-1:0] raddr;
  always_comb begin
    case (rd_cnt_r)
      3'd0:    raddr = line_addr(slot_y, x_r);
      3'd1:    raddr = line_addr(slot_y, lx);
      3'd2:    raddr = line_addr(slot_y, rx);
      3'd3:    raddr = line_addr(slot_dy, x_r);
      default: raddr = line_addr(slot_uy, x_r);
    endcase
  end

  logic [SW-1:0] rdata;
  hns_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
    .clk     (clk),
    .we      (accept),
    .waddr   (line_addr(slot_r, c0)),
    .wdata   (hns_pkg::clamp_sample(in_ch.height_sample)),
    .raddr   (raddr),
    .rdata_r (rdata)
  );

  // Absolute height differences and effective cell sizes.
  logic [SW-1:0] dx_abs, dz_abs;
  logic [15:0]   cx_eff, cz_eff;
  always_comb begin
    dx_abs = (hr_r >= hl_r) ? hr_r - hl_r : hl_r - hr_r;
    dz_abs = (hu_r >= hd_r) ? hu_r - hd_r : hd_r - hu_r;
    cx_eff = (cell_x_r == '0) ? 16'd1 : cell_x_r;
    cz_eff = (cell_z_r == '0) ? 16'd1 : cell_z_r;
  end

  // Shared multiplier operands.
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod_nxt;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      hns_pkg::ST_MUL_WH: begin
        mul_a = 32'(hs_r);
        mul_b = 32'(max_height_r);
      end
      hns_pkg::ST_MUL_AX: begin
        mul_a = 32'(dx_abs);
        mul_b = 32'(max_height_r);
      end
      hns_pkg::ST_MUL_AZ: begin
        mul_a = 32'(dz_abs);
        mul_b = 32'(max_height_r);
      end
      hns_pkg::ST_SQ_X: begin
        mul_a = gx_r;
        mul_b = gx_r;
      end
      hns_pkg::ST_SQ_Z: begin
        mul_a = gz_r;
        mul_b = gz_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_nxt = mul_a * mul_b;
  end

  // Iterative unit request.
  hns_pkg::unit_req_t  ureq;
  hns_pkg::unit_stat_t ustat;
  logic [63:0]         u_operand, u_div;
  logic [31:0]         u_result;
  logic                op_state;
  always_comb begin
    op_state   = 1'b0;
    ureq.op    = hns_pkg::OP_DIV;
    ureq.steps = hns_pkg::STEPS_W'(hns_pkg::QUO_STEPS_UNIT);
    u_operand  = '0;
    u_div      = '0;
    case (state_r)
      hns_pkg::ST_DIV_X: begin
        op_state   = 1'b1;
        ureq.steps = hns_pkg::STEPS_W'(hns_pkg::QUO_STEPS_GRAD);
        u_operand  = prod_r + 64'(cx_eff);
        u_div      = 64'({cx_eff, 1'b0}) << 31;
      end
      hns_pkg::ST_DIV_Z: begin
        op_state   = 1'b1;
        ureq.steps = hns_pkg::STEPS_W'(hns_pkg::QUO_STEPS_GRAD);
        u_operand  = prod_r + 64'(cz_eff);
        u_div      = 64'({cz_eff, 1'b0}) << 31;
      end
      hns_pkg::ST_SQRT: begin
        op_state   = 1'b1;
        ureq.op    = hns_pkg::OP_SQRT;
        ureq.steps = hns_pkg::STEPS_W'(hns_pkg::ROOT_STEPS);
        u_operand  = acc_r;
      end
      hns_pkg::ST_DIV_NX: begin
        op_state  = 1'b1;
        u_operand = 64'({gx_r, 16'h0000}) + 64'(s_r);
        u_div     = 64'({s_r, 1'b0}) << 15;
      end
      hns_pkg::ST_DIV_NY: begin
        op_state  = 1'b1;
        u_operand = 64'h1_0000_0000 + 64'(s_r);
        u_div     = 64'({s_r, 1'b0}) << 15;
      end
      hns_pkg::ST_DIV_NZ: begin
        op_state  = 1'b1;
        u_operand = 64'({gz_r, 16'h0000}) + 64'(s_r);
        u_div     = 64'({s_r, 1'b0}) << 15;
      end
      default: op_state = 1'b0;
    endcase
    ureq.start = op_state && !launched_r;
  end

  hns_unit u_unit (
    .clk             (clk),
    .rst_n           (rst_n),
    .req             (ureq),
    .operand         (u_operand),
    .divisor_aligned (u_div),
    .stat            (ustat),
    .result          (u_result)
  );

  // Saturated unit magnitude from the quotient.
  logic [14:0] mag_sat;
  assign mag_sat = (u_result[15:0] > 16'd32767) ? 15'd32767 : u_result[14:0];

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      hns_pkg::ST_IDLE:   if (accept) state_nxt = hns_pkg::ST_PICK;
      hns_pkg::ST_PICK:   state_nxt = (pend_r != '0) ? hns_pkg::ST_READ : hns_pkg::ST_IDLE;
      hns_pkg::ST_READ:   if (rd_cnt_r == 3'd5) state_nxt = hns_pkg::ST_MUL_WH;
      hns_pkg::ST_MUL_WH: state_nxt = hns_pkg::ST_MUL_AX;
      hns_pkg::ST_MUL_AX: state_nxt = hns_pkg::ST_DIV_X;
      hns_pkg::ST_DIV_X:  if (ustat.done) state_nxt = hns_pkg::ST_MUL_AZ;
      hns_pkg::ST_MUL_AZ: state_nxt = hns_pkg::ST_DIV_Z;
      hns_pkg::ST_DIV_Z:  if (ustat.done) state_nxt = hns_pkg::ST_SQ_X;
      hns_pkg::ST_SQ_X:   state_nxt = hns_pkg::ST_SQ_Z;
      hns_pkg::ST_SQ_Z:   state_nxt = hns_pkg::ST_SUM;
      hns_pkg::ST_SUM:    state_nxt = hns_pkg::ST_SQRT;
      hns_pkg::ST_SQRT:   if (ustat.done) state_nxt = hns_pkg::ST_DIV_NX;
      hns_pkg::ST_DIV_NX: if (ustat.done) state_nxt = hns_pkg::ST_DIV_NY;
      hns_pkg::ST_DIV_NY: if (ustat.done) state_nxt = hns_pkg::ST_DIV_NZ;
      hns_pkg::ST_DIV_NZ: if (ustat.done) state_nxt = hns_pkg::ST_OUT;
      hns_pkg::ST_OUT:    if (out_ch.ready) state_nxt = hns_pkg::ST_PICK;
      default:            state_nxt = hns_pkg::ST_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    in_ch.ready  = (state_r == hns_pkg::ST_IDLE);
    out_ch.valid = (state_r == hns_pkg::ST_OUT);
  end

  assign out_ch.grid_col     = o_col_r;
  assign out_ch.grid_row     = o_row_r;
  assign out_ch.world_height = o_wh_r;
  assign out_ch.normal_x     = o_nx_r;
  assign out_ch.normal_y     = o_ny_r;
  assign out_ch.normal_z     = o_nz_r;
  assign out_ch.last_of_run  = o_last_r;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= 11'd2;
      grid_height_r <= 16'd2;
      max_height_r  <= 16'd16;
      cell_x_r      <= 16'd16;
      cell_z_r      <= 16'd16;
    end else if (cfg_we) begin
      unique case (hns_pkg::cfg_idx_t'(cfg_index))
        hns_pkg::CFG_GRID_WIDTH:  grid_width_r  <= cfg_wdata[10:0];
        hns_pkg::CFG_GRID_HEIGHT: grid_height_r <= cfg_wdata;
        hns_pkg::CFG_MAX_HEIGHT:  max_height_r  <= cfg_wdata;
        hns_pkg::CFG_CELL_X:      cell_x_r      <= cfg_wdata;
        hns_pkg::CFG_CELL_Z:      cell_z_r      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Control state: position, sequencer, pending results, unit launch flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= hns_pkg::ST_IDLE;
      col_r      <= '0;
      row_r      <= '0;
      slot_r     <= '0;
      pend_r     <= '0;
      rd_cnt_r   <= '0;
      launched_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ureq.start) begin
        launched_r <= 1'b1;
      end else if (ustat.done) begin
        launched_r <= 1'b0;
      end
      if (accept) begin
        pend_r[0] <= (r0 != '0);
        pend_r[1] <= (r0 == h_eff - 16'd1) && (c0 != '0);
        pend_r[2] <= (r0 == h_eff - 16'd1) && (c0 == w_eff - WW'(1));
        if (c0 + WW'(1) >= w_eff) begin
          col_r  <= '0;
          slot_r <= (slot_r == 2'd2) ? 2'd0 : slot_r + 2'd1;
          row_r  <= (r0 + 16'd1 >= h_eff) ? 16'd0 : r0 + 16'd1;
        end else begin
          col_r <= c0 + WW'(1);
          row_r <= r0;
        end
      end
      if (state_r == hns_pkg::ST_PICK) begin
        rd_cnt_r <= '0;
        if (pend_r[0]) begin
          pend_r[0] <= 1'b0;
        end else if (pend_r[1]) begin
          pend_r[1] <= 1'b0;
        end else begin
          pend_r[2] <= 1'b0;
        end
      end else if (state_r == hns_pkg::ST_READ) begin
        rd_cnt_r <= rd_cnt_r + 3'd1;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (accept) begin
      stc_r <= c0;
      str_r <= r0;
      sts_r <= slot_r;
      sw_r  <= w_eff;
      sh_r  <= h_eff;
    end
    // Choose the next point to report.
    if (state_r == hns_pkg::ST_PICK) begin
      if (pend_r[0]) begin
        x_r    <= stc_r;
        y_r    <= str_r - 16'd1;
        last_r <= (pend_r[2:1] == 2'b00);
      end else if (pend_r[1]) begin
        x_r    <= stc_r - WW'(1);
        y_r    <= str_r;
        last_r <= !pend_r[2];
      end else begin
        x_r    <= stc_r;
        y_r    <= str_r;
        last_r <= 1'b1;
      end
    end
    // Capture the five neighbor samples.
    if (state_r == hns_pkg::ST_READ) begin
      case (rd_cnt_r)
        3'd1:    hs_r <= rdata;
        3'd2:    hl_r <= rdata;
        3'd3:    hr_r <= rdata;
        3'd4:    hd_r <= rdata;
        3'd5:    hu_r <= rdata;
        default: ;
      endcase
    end
    // World height, rounded and saturated.
    if (state_r == hns_pkg::ST_MUL_AX) begin
      wh_r <= (prod_r[63:32] != '0) ? 16'hFFFF : 16'((prod_r[31:0] + 32'd32768) >> 16);
    end
    if (state_r == hns_pkg::ST_SQ_Z) begin
      acc_r <= prod_r + 64'h1_0000_0000;
    end
    if (state_r == hns_pkg::ST_SUM) begin
      acc_r <= acc_r + prod_r;
    end
    // Results of the shared unit.
    if (ustat.done) begin
      case (state_r)
        hns_pkg::ST_DIV_X:  gx_r <= u_result;
        hns_pkg::ST_DIV_Z:  gz_r <= u_result;
        hns_pkg::ST_SQRT:   s_r  <= u_result;
        hns_pkg::ST_DIV_NX: nx_r <= mag_sat;
        hns_pkg::ST_DIV_NY: ny_r <= mag_sat;
        default: ;
      endcase
    end
    // Load the output register when the last component is done.
    if ((state_r == hns_pkg::ST_DIV_NZ) && ustat.done) begin
      o_col_r  <= 10'(x_r);
      o_row_r  <= y_r;
      o_wh_r   <= wh_r;
      o_nx_r   <= (hr_r > hl_r) ? 16'(-{1'b0, nx_r}) : {1'b0, nx_r};
      o_ny_r   <= ny_r;
      o_nz_r   <= (hu_r > hd_r) ? 16'(-{1'b0, mag_sat}) : {1'b0, mag_sat};
      o_last_r <= last_r;
    end
  end

endmodule

FILE: rtl/hns_checker.sv
// Port-level checker for the height-field normal stream, bound to the top level.
`include "heightfield_normal_stream_assert.svh"

module hns_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] normal_x,
  input logic [15:0] normal_z
);

  // A result waiting for transfer blocks new samples.
  `HNS_ASSERT_NOW(a_out_blocks_in, out_valid, !in_ready, "sample taken while result pending")

  // In the cycle after a sample transfer the block is not ready for another sample.
  `HNS_ASSERT_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready, "ready right after sample")

  // A stalled result stays offered.
  `HNS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

  // Normal components never reach the most negative code.
  `HNS_ASSERT_NOW(a_normal_range, out_valid, (normal_x != 16'h8000) && (normal_z != 16'h8000),
    "normal component out of range")

endmodule

bind heightfield_normal_stream hns_checker u_hns_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .normal_x  (out_ch.normal_x),
  .normal_z  (out_ch.normal_z)
);
